// ----- hw/rtl/b64d_pkg.sv -----
// shared types, status codes and alphabet lookup for the base64 stream decoder
package b64d_pkg;

   // character codes
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_PAD     = 8'h3d;

   // result status codes
   localparam logic [2:0] ST_OK              = 3'd0;
   localparam logic [2:0] ST_MISPLACED_PAD   = 3'd1;
   localparam logic [2:0] ST_INVALID_CHAR    = 3'd2;
   localparam logic [2:0] ST_MISSING_NEWLINE = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE      = 3'd4;

   // input transaction
   typedef struct packed {
      logic       action;
      logic [7:0] char_in;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0] byte_out;
      logic       has_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // one front-end command: one to three results caused by one input item
   typedef struct packed {
      logic [1:0]      n_res;
      logic [2:0][7:0] bytes;
      logic            has_byte;
      logic [2:0]      status0;
   } cmd_type;

   // queue fill state seen by the top level and the back end
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // lookup result: known flag and 6-bit value
   typedef struct packed {
      logic       known;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type r;
      r.known = 1'b1;
      r.value = 6'd0;
      if (c inside {[8'h41:8'h5a]}) begin
         r.value = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7a]}) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         r.value = 6'd62;
      end else if (c == 8'h2f) begin
         r.value = 6'd63;
      end else begin
         r.known = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/b64d_front.sv -----
// front end: accepts characters, tracks group state, issues result commands
module b64d_front
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    cmd_push,
   output cmd_type cmd
);

   logic [2:0][5:0] vals_ff, vals_in;
   logic [1:0]      pad_ff, pad_in;
   logic            inv_ff, inv_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            pad_seen_ff, pad_seen_in;
   logic            exp_nl_ff, exp_nl_in;
   logic            halted_ff, halted_in;

   sextet_type sx;
   logic       is_pad;
   logic       bad;
   logic [5:0] v0, v1, v2, v3;

   assign sx     = sextet_of(req.char_in);
   assign is_pad = (req.char_in == CH_PAD);
   assign v0     = vals_ff[0];
   assign v1     = vals_ff[1];
   assign v2     = vals_ff[2];
   assign v3     = sx.value;
   assign bad    = inv_ff | (~sx.known & ~is_pad);

   always_comb begin
      vals_in     = vals_ff;
      pad_in      = pad_ff;
      inv_in      = inv_ff;
      cnt_in      = cnt_ff;
      pad_seen_in = pad_seen_ff;
      exp_nl_in   = exp_nl_ff;
      halted_in   = halted_ff;
      cmd_push    = 1'b0;
      cmd         = '0;
      cmd.n_res   = 2'd1;
      if (accept && !halted_ff) begin
         if (req.action) begin
            // end of stream
            if (cnt_ff != 2'd0) begin
               cmd_push    = 1'b1;
               cmd.status0 = ST_INCOMPLETE;
            end
            pad_in      = '0;
            inv_in      = 1'b0;
            cnt_in      = '0;
            pad_seen_in = 1'b0;
            exp_nl_in   = 1'b0;
         end else if (exp_nl_ff) begin
            exp_nl_in = 1'b0;
            if (req.char_in != CH_NEWLINE) begin
               cmd_push    = 1'b1;
               cmd.status0 = ST_MISSING_NEWLINE;
            end
         end else if (req.char_in == CH_NEWLINE) begin
            // skipped
         end else if (cnt_ff != 2'd3) begin
            vals_in[cnt_ff] = sx.value;
            if (is_pad) begin
               if (cnt_ff == 2'd2) begin
                  pad_in[1] = 1'b1;
               end else begin
                  pad_in[0] = 1'b1;
               end
            end
            if (!sx.known && !is_pad) begin
               inv_in = 1'b1;
            end
            cnt_in = cnt_ff + 2'd1;
         end else begin
            // fourth character completes the group
            pad_in   = '0;
            inv_in   = 1'b0;
            cnt_in   = '0;
            cmd_push = 1'b1;
            if (pad_ff[0] || (pad_ff[1] && !is_pad)) begin
               halted_in   = 1'b1;
               cmd.status0 = ST_MISPLACED_PAD;
            end else begin
               cmd.has_byte = 1'b1;
               cmd.status0  = bad ? ST_INVALID_CHAR : ST_OK;
               cmd.bytes[0] = {v0, v1[5:4]};
               cmd.bytes[1] = {v1[3:0], v2[5:2]};
               cmd.bytes[2] = {v2[1:0], v3};
               if (pad_ff[1]) begin
                  cmd.n_res = 2'd1;
               end else if (is_pad) begin
                  cmd.n_res = 2'd2;
               end else begin
                  cmd.n_res = 2'd3;
               end
               pad_seen_in = pad_seen_ff | pad_ff[1] | is_pad;
               exp_nl_in   = pad_seen_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals_in;
      if (reset) begin
         pad_ff      <= '0;
         inv_ff      <= 1'b0;
         cnt_ff      <= '0;
         pad_seen_ff <= 1'b0;
         exp_nl_ff   <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         pad_ff      <= pad_in;
         inv_ff      <= inv_in;
         cnt_ff      <= cnt_in;
         pad_seen_ff <= pad_seen_in;
         exp_nl_ff   <= exp_nl_in;
         halted_ff   <= halted_in;
      end
   end

endmodule

// ----- hw/rtl/b64d_queue.sv -----
// command queue between the front end and the back end
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    head_cmd,
   output q_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   used_ff, used_in;
   logic            do_push, do_pop;

   assign stat.full  = (used_ff == CW'(DEPTH));
   assign stat.empty = (used_ff == '0);
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         used_in = used_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         used_in = used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

endmodule

// ----- hw/rtl/b64d_back.sv -----
// back end: walks each queued command out as one to three result transactions
module b64d_back
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  q_stat_type stat,
   input  logic       rsp_pop,
   output logic       cmd_pop,
   output rsp_type    rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       is_last;
   logic       take;

   assign is_last      = (idx_ff == head_cmd.n_res - 2'd1);
   assign take         = rsp_pop & ~stat.empty;
   assign cmd_pop      = take & is_last;

   assign rsp.byte_out = head_cmd.has_byte ? head_cmd.bytes[idx_ff] : 8'd0;
   assign rsp.has_byte = head_cmd.has_byte;
   assign rsp.status   = (idx_ff == 2'd0) ? head_cmd.status0 : ST_OK;
   assign rsp.last     = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- hw/rtl/base64_stream_decoder_top.sv -----
// top level of the streaming base64 decoder
//
//   channel | ports                          | transaction
//   --------+--------------------------------+------------------------------------
//   request | req_push, req_full, req_data   | one character or end of stream
//   result  | rsp_pop, rsp_empty, rsp_data   | one decoded byte or status report
//
// one request transaction is taken per cycle while the command queue has room;
// the front end decides all results of a character in that same cycle.
// one result transaction leaves per cycle while results are queued; a full group
// gives up to three, so four characters in yield at most three results out.
// reset (synchronous, active high) clears group state, the halt flag and the queue.
// a stalled result side fills the QUEUE_DEPTH-entry queue, then req_full rises.
module base64_stream_decoder_top
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   // request side
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   // result side
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   q_stat_type q_stat;
   cmd_type    f_cmd;
   cmd_type    head_cmd;
   logic       f_push;
   logic       b_pop;
   logic       accept;

   // request accepted whenever the queue can take a command
   assign accept    = req_push & ~q_stat.full;
   assign req_full  = q_stat.full;
   assign rsp_empty = q_stat.empty;

   // front end: grouping, classification, byte assembly
   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cmd_push (f_push),
      .cmd      (f_cmd)
   );

   // decouples character intake from result delivery
   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_cmd (f_cmd),
      .pop      (b_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   // back end: serializes each command into result transactions
   b64d_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .stat     (q_stat),
      .rsp_pop  (rsp_pop),
      .cmd_pop  (b_pop),
      .rsp      (rsp_data)
   );

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the streaming base64 decoder
import b64d_pkg::*;

// tracks the decoder state and the results it owes, checks results in order
class decoder_scoreboard;
   logic [5:0]  held_values [3];
   bit          pad_early;      // '=' held in position 0 or 1
   bit          pad_third;      // '=' held in position 2
   bit          held_bad;       // unknown character held in the group
   int unsigned held_count;
   bit          padded_before;  // a padded group was decoded in this stream
   bit          want_newline;
   bit          stopped;
   rsp_type     pending_results [$];
   int          mismatches = 0;

   function void clear_group();
      foreach (held_values[i]) held_values[i] = '0;
      pad_early  = 1'b0;
      pad_third  = 1'b0;
      held_bad   = 1'b0;
      held_count = 0;
   endfunction

   function void expect_result(logic [7:0] b, logic h, logic [2:0] st, logic lst);
      rsp_type r;
      r.byte_out = b;
      r.has_byte = h;
      r.status   = st;
      r.last     = lst;
      pending_results.push_back(r);
   endfunction

   function void accept_item(req_type item);
      logic [7:0]  c;
      logic [5:0]  v;
      logic [7:0]  bytes [3];
      bit          known;
      bit          is_pad;
      int unsigned n;
      c = item.char_in;
      if (stopped) return;
      if (item.action) begin
         if (held_count != 0) expect_result(8'h00, 1'b0, ST_INCOMPLETE, 1'b1);
         clear_group();
         padded_before = 1'b0;
         want_newline  = 1'b0;
         return;
      end
      if (want_newline) begin
         want_newline = 1'b0;
         if (c != CH_NEWLINE) expect_result(8'h00, 1'b0, ST_MISSING_NEWLINE, 1'b1);
         return;
      end
      if (c == CH_NEWLINE) return;
      is_pad = (c == CH_PAD);
      known  = 1'b1;
      v      = '0;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin
         v = 6'd62;
      end else if (c == 8'h2f) begin
         v = 6'd63;
      end else begin
         known = 1'b0;
      end
      if (held_count < 3) begin
         held_values[held_count] = v;
         if (is_pad) begin
            if (held_count < 2) pad_early = 1'b1;
            else pad_third = 1'b1;
         end
         if (!known && !is_pad) held_bad = 1'b1;
         held_count++;
         return;
      end
      if (pad_early || (pad_third && !is_pad)) begin
         clear_group();
         stopped = 1'b1;
         expect_result(8'h00, 1'b0, ST_MISPLACED_PAD, 1'b1);
         return;
      end
      n = pad_third ? 1 : (is_pad ? 2 : 3);
      if (n < 3) padded_before = 1'b1;
      bytes[0] = {held_values[0], held_values[1][5:4]};
      bytes[1] = {held_values[1][3:0], held_values[2][5:2]};
      bytes[2] = {held_values[2][1:0], v};
      for (int i = 0; i < n; i++)
         expect_result(bytes[i], 1'b1,
                       (i == 0 && (held_bad || (!known && !is_pad))) ? ST_INVALID_CHAR : ST_OK,
                       i == n - 1);
      clear_group();
      if (padded_before) want_newline = 1'b1;
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: byte %02h has_byte %0d status %0d last %0d",
                     got.byte_out, got.has_byte, got.status, got.last);
         return;
      end
      want = pending_results.pop_front();
      if (got.byte_out !== want.byte_out || got.has_byte !== want.has_byte ||
          got.status !== want.status || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected byte %02h has_byte %0d status %0d last %0d,",
                      " got byte %02h has_byte %0d status %0d last %0d"},
                     want.byte_out, want.has_byte, want.status, want.last,
                     got.byte_out, got.has_byte, got.status, got.last);
      end
   endfunction
endclass

module testbench;

   // action field codes
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam int    RANDOM_ITEMS = 70;
   localparam int    HOLD_AFTER   = 20;    // results taken before the long receiver stall
   localparam int    HOLD_CYCLES  = 80;
   localparam int    DRAIN_CYCLES = 20;
   localparam int    TIMEOUT      = 500000;
   localparam string ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop = 1'b0;
   logic    rsp_empty;
   rsp_type rsp_data;

   // shared between sender and receiver: no idle cycles on either side
   bit no_idle = 1'b0;
   int items_sent = 0;

   // model checks the block; planner mirrors it on the stimulus side so that
   // random traffic never halts the decoder before the very end
   decoder_scoreboard model   = new;
   decoder_scoreboard planner = new;

   base64_stream_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   initial begin
      #(TIMEOUT);
      $display("FAIL");
      $finish;
   end

   // both handshakes are sampled at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset) begin
         // request side first: a transaction accepted here precedes any result it causes
         if (req_push && !req_full) model.accept_item(req_data);
         if (rsp_pop && !rsp_empty) model.check_result(rsp_data);
      end
   end

   // bends a random character so that no misplaced pad can complete a group
   function automatic logic [7:0] keep_safe(input logic [7:0] ch);
      if (planner.want_newline || ch == CH_NEWLINE) return ch;
      if (planner.held_count < 2 && ch == CH_PAD) return 8'h51;
      if (planner.held_count == 3 && planner.pad_third && ch != CH_PAD) return CH_PAD;
      return ch;
   endfunction

   // one request transaction, after a random number of idle cycles
   task automatic send(input logic act, input logic [7:0] ch);
      int      gap;
      req_type item;
      item.action  = act;
      item.char_in = ch;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      planner.accept_item(item);
      planner.pending_results.delete();
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send(ACT_CHAR, s[i]);
   endtask

   // result side: random pops, one long stall to back the queue up
   initial begin : result_side
      int gap;
      int taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 3);
         if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         taken++;
      end
   end

   // request side and end of run
   initial begin : request_side
      int         target;
      int         groups;
      int         pads;
      int         kind;
      logic [7:0] ch;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (reset);

      // directed: full group, values 63 and 62, newline inside a group with an
      // unknown character, one- and two-byte padding, missing newline after a
      // padded group, end of stream inside a group and on an empty group
      send_text("TWFu");
      send_text("//+/");
      send_text("A\n");
      send(ACT_CHAR, 8'hff);
      send_text("9w");
      send_text("TQ==\n");
      send_text("TWE=Z");
      send_text("QU");
      send(ACT_END, 8'h00);
      send(ACT_END, 8'hff);

      // random: mostly well-formed lines, some noise
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) != 0) begin
            groups = $urandom_range(1, 4);
            pads   = $urandom_range(0, 2);
            for (int g = 0; g < groups; g++) begin
               for (int k = 0; k < 4; k++) begin
                  if ($urandom_range(0, 15) == 0) send(ACT_CHAR, CH_NEWLINE);
                  if (g == groups - 1 && k >= 4 - pads) ch = CH_PAD;
                  else if ($urandom_range(0, 19) == 0) ch = 8'($urandom_range(0, 255));
                  else ch = ALPHABET[$urandom_range(0, 63)];
                  send(ACT_CHAR, keep_safe(ch));
               end
            end
            // line end: usually a newline, sometimes junk or end of stream
            kind = $urandom_range(0, 5);
            if (kind == 0) begin
               ch = 8'($urandom_range(0, 255));
               send(ACT_CHAR, keep_safe(ch));
            end else if (kind == 1) begin
               send(ACT_END, 8'($urandom_range(0, 255)));
            end else begin
               send(ACT_CHAR, CH_NEWLINE);
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               ch = 8'($urandom_range(0, 255));
               if ($urandom_range(0, 5) == 0) send(ACT_END, ch);
               else send(ACT_CHAR, keep_safe(ch));
            end
         end
      end
      no_idle = 1'b0;

      // misplaced pad halts the block for good, so it comes last
      send(ACT_END, 8'h00);
      kind = $urandom_range(0, 2);
      case (kind)
         0: send_text("=BCD");
         1: send_text("B=CD");
         default: send_text("BC=D");
      endcase
      // halted: neither characters nor end of stream give results
      send_text("TWFu");
      send(ACT_END, 8'h00);
      req_push <= 1'b0;

      while (model.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (model.mismatches == 0 && model.pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
